@@ design/piaw_pkg.sv @@
package piaw_pkg;

    // field widths
    localparam int DATA_W   = 32;
    localparam int STEP_W   = 31;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = 16;

    // internal widths
    localparam int ERR_W     = DATA_W + 1;          // exact demand - measured
    localparam int INTEG_W   = 48;                  // integrator, Q32.16
    localparam int MUL_W     = ERR_W;               // shared multiplier operand width
    localparam int PROD_W    = 2 * MUL_W;           // full product width
    localparam int SPLIT_W   = 24;                  // integrator split for the 33x33 unit
    localparam int HI_W      = INTEG_W - SPLIT_W;
    localparam int ACC_W     = 80;                  // integral product accumulator
    localparam int U_W       = ACC_W - FRAC_W;      // unclamped drive

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_UPPER = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LOWER = CFG_IDX_W'(4);

    // reset value of the upper clamp, 1100.0 in Q16.16
    localparam logic signed [DATA_W-1:0] UPPER_RESET = DATA_W'(72089600);

    // integrator saturation bounds
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

    // clamp status codes
    localparam logic [STATUS_W-1:0] CLAMP_NONE = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] CLAMP_HIGH = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] CLAMP_LOW  = STATUS_W'(2);

    // datapath operations
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_STEP,
        OP_MUL_PROP,
        OP_MUL_ILO,
        OP_MUL_IHI,
        OP_SUM
    } op_t;

    typedef struct packed {
        op_t  op;
        logic commit;
    } cmd_t;

endpackage

@@ design/piaw_in_if.sv @@
interface piaw_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [piaw_pkg::DATA_W-1:0]   demand;
    logic signed [piaw_pkg::DATA_W-1:0]   measured;

    modport source (output valid, output demand, output measured, input ready);
    modport sink (input valid, input demand, input measured, output ready);
endinterface

@@ design/piaw_out_if.sv @@
interface piaw_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [piaw_pkg::DATA_W-1:0]   drive;
    logic [piaw_pkg::STATUS_W-1:0]        clamp_status;
    logic                                 integ_held;

    modport source (output valid, output drive, output clamp_status, output integ_held,
                    input ready);
    modport sink (input valid, input drive, input clamp_status, input integ_held,
                  output ready);
endinterface

@@ design/piaw_cfg_if.sv @@
interface piaw_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [piaw_pkg::CFG_IDX_W-1:0]       index;
    logic [piaw_pkg::DATA_W-1:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/piaw_ctrl.sv @@
module piaw_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output piaw_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_STEP,
        ST_MUL_PROP,
        ST_MUL_ILO,
        ST_MUL_IHI,
        ST_SUM,
        ST_CLAMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op         = piaw_pkg::OP_NONE;
        cmd.commit     = 1'b0;
        state_next     = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = piaw_pkg::OP_LOAD;
                    state_next = ST_MUL_STEP;
                end
            end
            ST_MUL_STEP:
            begin
                cmd.op     = piaw_pkg::OP_MUL_STEP;
                state_next = ST_MUL_PROP;
            end
            ST_MUL_PROP:
            begin
                cmd.op     = piaw_pkg::OP_MUL_PROP;
                state_next = ST_MUL_ILO;
            end
            ST_MUL_ILO:
            begin
                cmd.op     = piaw_pkg::OP_MUL_ILO;
                state_next = ST_MUL_IHI;
            end
            ST_MUL_IHI:
            begin
                cmd.op     = piaw_pkg::OP_MUL_IHI;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = piaw_pkg::OP_SUM;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // wait for the output slot to drain
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over an untaken result");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("committed result not presented");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL_STEP))
        else $error("accepted request did not start the sequence");

endmodule

@@ design/piaw_dp.sv @@
module piaw_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  piaw_pkg::cmd_t                        cmd,
    input  logic signed [piaw_pkg::DATA_W-1:0]    demand,
    input  logic signed [piaw_pkg::DATA_W-1:0]    measured,
    input  logic                                  cfg_we,
    input  logic [piaw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [piaw_pkg::DATA_W-1:0]           cfg_data,
    output logic signed [piaw_pkg::DATA_W-1:0]    drive,
    output logic [piaw_pkg::STATUS_W-1:0]         clamp_status,
    output logic                                  integ_held
);

    // configuration
    logic signed [piaw_pkg::DATA_W-1:0] prop_gain_reg;
    logic signed [piaw_pkg::DATA_W-1:0] integ_gain_reg;
    logic [piaw_pkg::STEP_W-1:0]        step_size_reg;
    logic signed [piaw_pkg::DATA_W-1:0] drive_upper_reg;
    logic signed [piaw_pkg::DATA_W-1:0] drive_lower_reg;

    // state and working registers
    logic signed [piaw_pkg::INTEG_W-1:0] accum_reg;
    logic signed [piaw_pkg::ERR_W-1:0]   err_reg;
    logic signed [piaw_pkg::PROD_W-1:0]  prod_reg;
    logic signed [piaw_pkg::INTEG_W-1:0] sum_reg;
    logic signed [piaw_pkg::ACC_W-1:0]   acc_reg;
    logic signed [piaw_pkg::U_W-1:0]     u_reg;
    logic signed [piaw_pkg::DATA_W-1:0]  drive_reg;
    logic [piaw_pkg::STATUS_W-1:0]       status_reg;
    logic                                held_reg;

    // shared multiplier
    logic signed [piaw_pkg::MUL_W-1:0]   mul_a;
    logic signed [piaw_pkg::MUL_W-1:0]   mul_b;
    logic signed [piaw_pkg::PROD_W-1:0]  mul_p;

    logic signed [piaw_pkg::ERR_W-1:0]   err_next;
    logic signed [piaw_pkg::INTEG_W-1:0] step_term;
    logic signed [piaw_pkg::INTEG_W:0]   sum_wide;
    logic signed [piaw_pkg::INTEG_W-1:0] sum_next;
    logic signed [piaw_pkg::ACC_W-1:0]   prod_ext;
    logic signed [piaw_pkg::ACC_W-1:0]   acc_final;
    logic signed [piaw_pkg::U_W-1:0]     upper_ext;
    logic signed [piaw_pkg::U_W-1:0]     lower_ext;
    logic                                above;
    logic                                below;
    logic                                err_pos;
    logic                                err_neg;
    logic signed [piaw_pkg::DATA_W-1:0]  drive_next;
    logic [piaw_pkg::STATUS_W-1:0]       status_next;
    logic                                held_next;

    assign err_next = {demand[piaw_pkg::DATA_W-1], demand}
                    - {measured[piaw_pkg::DATA_W-1], measured};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            piaw_pkg::OP_MUL_STEP:
            begin
                mul_a = {{(piaw_pkg::MUL_W-piaw_pkg::STEP_W){1'b0}}, step_size_reg};
                mul_b = err_reg;
            end
            piaw_pkg::OP_MUL_PROP:
            begin
                mul_a = err_reg;
                mul_b = {prop_gain_reg[piaw_pkg::DATA_W-1], prop_gain_reg};
            end
            piaw_pkg::OP_MUL_ILO:
            begin
                mul_a = {{(piaw_pkg::MUL_W-piaw_pkg::SPLIT_W){1'b0}},
                         sum_reg[piaw_pkg::SPLIT_W-1:0]};
                mul_b = {integ_gain_reg[piaw_pkg::DATA_W-1], integ_gain_reg};
            end
            piaw_pkg::OP_MUL_IHI:
            begin
                mul_a = {{(piaw_pkg::MUL_W-piaw_pkg::HI_W){sum_reg[piaw_pkg::INTEG_W-1]}},
                         sum_reg[piaw_pkg::INTEG_W-1:piaw_pkg::SPLIT_W]};
                mul_b = {integ_gain_reg[piaw_pkg::DATA_W-1], integ_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // step term: floor(step*err / 2^16) always fits the integrator width
    assign step_term = prod_reg[piaw_pkg::FRAC_W+piaw_pkg::INTEG_W-1:piaw_pkg::FRAC_W];
    assign sum_wide  = {accum_reg[piaw_pkg::INTEG_W-1], accum_reg}
                     + {step_term[piaw_pkg::INTEG_W-1], step_term};

    always_comb
    begin
        if (sum_wide[piaw_pkg::INTEG_W] != sum_wide[piaw_pkg::INTEG_W-1])
            sum_next = sum_wide[piaw_pkg::INTEG_W] ? piaw_pkg::INTEG_MIN : piaw_pkg::INTEG_MAX;
        else
            sum_next = sum_wide[piaw_pkg::INTEG_W-1:0];
    end

    assign prod_ext  = {{(piaw_pkg::ACC_W-piaw_pkg::PROD_W){prod_reg[piaw_pkg::PROD_W-1]}},
                        prod_reg};
    // high half of the integral product, weighted by the split
    assign acc_final = acc_reg
                     + {prod_reg[piaw_pkg::ACC_W-piaw_pkg::SPLIT_W-1:0],
                        {piaw_pkg::SPLIT_W{1'b0}}};

    // clamp and anti-windup decision
    assign upper_ext = {{(piaw_pkg::U_W-piaw_pkg::DATA_W){drive_upper_reg[piaw_pkg::DATA_W-1]}},
                        drive_upper_reg};
    assign lower_ext = {{(piaw_pkg::U_W-piaw_pkg::DATA_W){drive_lower_reg[piaw_pkg::DATA_W-1]}},
                        drive_lower_reg};
    assign above     = (u_reg > upper_ext);
    assign below     = (u_reg < lower_ext);
    assign err_neg   = err_reg[piaw_pkg::ERR_W-1];
    assign err_pos   = !err_reg[piaw_pkg::ERR_W-1] && (|err_reg);

    always_comb
    begin
        if (above)
        begin
            drive_next  = drive_upper_reg;
            status_next = piaw_pkg::CLAMP_HIGH;
            held_next   = err_pos;
        end
        else if (below)
        begin
            drive_next  = drive_lower_reg;
            status_next = piaw_pkg::CLAMP_LOW;
            held_next   = err_neg;
        end
        else
        begin
            drive_next  = u_reg[piaw_pkg::DATA_W-1:0];
            status_next = piaw_pkg::CLAMP_NONE;
            held_next   = 1'b0;
        end
    end

    // configuration and integrator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            step_size_reg   <= '0;
            drive_upper_reg <= piaw_pkg::UPPER_RESET;
            drive_lower_reg <= '0;
            accum_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    piaw_pkg::REG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                    piaw_pkg::REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                    piaw_pkg::REG_STEP_SIZE:   step_size_reg   <= cfg_data[piaw_pkg::STEP_W-1:0];
                    piaw_pkg::REG_DRIVE_UPPER: drive_upper_reg <= cfg_data;
                    piaw_pkg::REG_DRIVE_LOWER: drive_lower_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.commit && !held_next)
                accum_reg <= sum_reg;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.op == piaw_pkg::OP_LOAD)
            err_reg <= err_next;
        if (cmd.op == piaw_pkg::OP_MUL_STEP || cmd.op == piaw_pkg::OP_MUL_PROP ||
            cmd.op == piaw_pkg::OP_MUL_ILO || cmd.op == piaw_pkg::OP_MUL_IHI)
            prod_reg <= mul_p;
        if (cmd.op == piaw_pkg::OP_MUL_PROP)
            sum_reg <= sum_next;
        // proportional term floored on its own, so the two terms truncate separately
        if (cmd.op == piaw_pkg::OP_MUL_ILO)
            acc_reg <= {prod_ext[piaw_pkg::ACC_W-1:piaw_pkg::FRAC_W], {piaw_pkg::FRAC_W{1'b0}}};
        if (cmd.op == piaw_pkg::OP_MUL_IHI)
            acc_reg <= acc_reg + prod_ext;
        if (cmd.op == piaw_pkg::OP_SUM)
            u_reg <= acc_final[piaw_pkg::ACC_W-1:piaw_pkg::FRAC_W];
        if (cmd.commit)
        begin
            drive_reg  <= drive_next;
            status_reg <= status_next;
            held_reg   <= held_next;
        end
    end

    assign drive        = drive_reg;
    assign clamp_status = status_reg;
    assign integ_held   = held_reg;

    a_accum_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(accum_reg))
        else $error("integrator moved outside a commit");

endmodule

@@ design/pi_controller_antiwindup_unit.sv @@
// pi controller with conditional-integration anti-windup, signed q16.16 data and gains.
// each request carries demand and measured; the block forms error = demand - measured,
// sum = sat48(integrator + floor(step_size*error/2^16)) and
// drive = floor(error*prop_gain/2^16) + floor(sum*integ_gain/2^16), clamps drive to
// drive_upper / drive_lower (upper test first) and holds the integrator when clamped
// high with positive error or clamped low with negative error. one request is worked
// at a time: its pace is set by the single shared 33x33 multiplier that is used four
// times in sequence (step term, proportional term, low and high halves of the
// integral term), followed by an add step and a clamp step. the result sits in an
// output register, so the next request is taken while the previous result still
// waits downstream; the clamp step stalls only when a result is still unclaimed.
// configuration writes are always accepted and must be made while the block is idle.
module pi_controller_antiwindup_unit (
    input  logic        clk,
    input  logic        rst_n,
    piaw_in_if.sink     sample,
    piaw_out_if.source  result,
    piaw_cfg_if.sink    cfg
);

    // command from the sequencer to the datapath
    piaw_pkg::cmd_t cmd;
    logic           in_ready;
    logic           out_valid;

    // configuration writes never stall
    assign cfg.ready = 1'b1;

    // sequencer: one state per multiplier pass, then add and clamp
    piaw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // datapath: config registers, integrator, shared multiplier, clamp, result register
    piaw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .demand       (sample.demand),
        .measured     (sample.measured),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .drive        (result.drive),
        .clamp_status (result.clamp_status),
        .integ_held   (result.integ_held)
    );

    // request handshake
    assign sample.ready = in_ready;
    assign result.valid = out_valid;

endmodule
